// ===== rtl/vis_pkg.sv =====
// ----------------------------------------------------------------------------
// vis_pkg : shared types and constants for the vote interval schedule
// Field widths, stream packing offsets, register indexes and the records
// that travel along the divider cell chain.
// ----------------------------------------------------------------------------
package vis_pkg;

  // time and register widths
  localparam int unsigned TIME_BITS    = 40;
  localparam int unsigned OUT_BITS     = TIME_BITS + 1;
  localparam int unsigned REG_BITS     = 17;
  // offsets from midnight, with headroom for start offset and one interval
  localparam int unsigned REL_BITS     = REG_BITS + 2;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [REG_BITS-1:0] DAY_SECONDS = REG_BITS'(24 * 60 * 60);

  // one cell per quotient bit
  localparam int unsigned MOD_CELLS = TIME_BITS;
  localparam int unsigned DIV_CELLS = REG_BITS;

  // register reset values
  localparam logic [REG_BITS-1:0] INTERVAL_RST     = REG_BITS'(1800);
  localparam logic [REG_BITS-1:0] VOTE_LEAD_RST    = REG_BITS'(300);
  localparam logic [REG_BITS-1:0] PUB_LEAD_RST     = REG_BITS'(300);
  localparam logic [REG_BITS-1:0] START_OFFSET_RST = '0;

  // stream packing
  localparam int unsigned IN_FIELD_BITS  = 3 * TIME_BITS + 2 * REG_BITS;
  localparam int unsigned IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned IN_NOW_LSB     = 0;
  localparam int unsigned IN_VA_LSB      = TIME_BITS;
  localparam int unsigned IN_FU_LSB      = 2 * TIME_BITS;
  localparam int unsigned IN_VOTE_LSB    = 3 * TIME_BITS;
  localparam int unsigned IN_DIST_LSB    = 3 * TIME_BITS + REG_BITS;
  localparam int unsigned OUT_FIELD_BITS = 5 * OUT_BITS;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INTERVAL     = 2'd0,
    REG_VOTE_LEAD    = 2'd1,
    REG_PUB_LEAD     = 2'd2,
    REG_START_OFFSET = 2'd3
  } cfg_reg_e;

  // per-request values carried untouched along the chain
  typedef struct packed {
    logic [TIME_BITS-1:0] now;
    logic [REG_BITS-1:0]  ivl;
    logic [REG_BITS-1:0]  vote;
    logic [REG_BITS-1:0]  pub;    // distribution delay
    logic                 ok;
    logic [REG_BITS-1:0]  frac;   // seconds since midnight
  } side_t;

  // restoring division record handed from cell to cell
  typedef struct packed {
    logic [REG_BITS-1:0]  rem;
    logic [REG_BITS-1:0]  quo;
    logic [TIME_BITS-1:0] dvd;    // dividend, next bit at the top
    logic [REG_BITS-1:0]  dsr;
    side_t                side;
  } cell_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] fetch_sig;
    logic [OUT_BITS-1:0] vote_end;
    logic [OUT_BITS-1:0] fetch_votes;
    logic [OUT_BITS-1:0] vote_start;
    logic                bad;
  } res_t;

endpackage

// ===== rtl/vis_cell.sv =====
// ----------------------------------------------------------------------------
// vis_cell : one restoring division step
// Shifts the next dividend bit into the remainder, subtracts the divisor
// when it fits and records the quotient bit. Registered output.
// ----------------------------------------------------------------------------
module vis_cell import vis_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cell_t cell_i,
  output logic  valid_o,
  output cell_t cell_o
);

  logic              valid_q;
  cell_t             cell_q, cell_d;
  logic [REG_BITS:0] trial, diff;
  logic              fits;

  always_comb begin
    trial = {cell_i.rem, cell_i.dvd[TIME_BITS-1]};
    diff  = trial - {1'b0, cell_i.dsr};
    fits  = trial >= {1'b0, cell_i.dsr};
    cell_d      = cell_i;
    cell_d.rem  = fits ? diff[REG_BITS-1:0] : trial[REG_BITS-1:0];
    cell_d.quo  = {cell_i.quo[REG_BITS-2:0], fits};
    cell_d.dvd  = {cell_i.dvd[TIME_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== rtl/vis_tail.sv =====
// ----------------------------------------------------------------------------
// vis_tail : schedule arithmetic after the divider chain
// Four stages: next boundary and delay clamp, day clamp plus offset,
// step back, then absolute start; deadlines are formed on the way out.
// ----------------------------------------------------------------------------
module vis_tail import vis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  cell_t               cell_i,
  input  logic [REG_BITS-1:0] start_offset_i,
  output logic                valid_o,
  output res_t                res_o
);

  // stage 1
  logic                 p1_valid_q;
  logic [TIME_BITS-1:0] p1_midnight_q, p1_midnight_d;
  logic [REL_BITS-1:0]  p1_next_q, p1_next_d;
  logic [REG_BITS-1:0]  p1_frac_q, p1_ivl_q, p1_vote_q, p1_vote_d, p1_dist_q, p1_dist_d;
  logic                 p1_ok_q;
  logic [REG_BITS:0]    delay_sum;
  logic                 delay_long;

  // stage 2
  logic                 p2_valid_q;
  logic [TIME_BITS-1:0] p2_midnight_q;
  logic [REL_BITS-1:0]  p2_next_q, p2_next_d, day_next;
  logic [REG_BITS-1:0]  p2_frac_q, p2_ivl_q, p2_vote_q, p2_dist_q;
  logic                 p2_ok_q;

  // stage 3
  logic                 p3_valid_q;
  logic [TIME_BITS-1:0] p3_midnight_q;
  logic [REL_BITS-1:0]  p3_rel_q, p3_rel_d, step_limit;
  logic [REL_BITS-1:0]  p3_dhalf_q, p3_dfull_q, p3_dvhalf_q, p3_dvfull_q;
  logic                 p3_ok_q;

  // stage 4
  logic                 p4_valid_q;
  logic [OUT_BITS-1:0]  p4_start_q;
  logic [REL_BITS-1:0]  p4_dhalf_q, p4_dfull_q, p4_dvhalf_q, p4_dvfull_q;
  logic                 p4_ok_q;

  // next boundary = midnight + (q+1)*ivl, and (q*ivl) = frac - rem
  always_comb begin
    p1_midnight_d = cell_i.side.now - TIME_BITS'(cell_i.side.frac);
    p1_next_d     = REL_BITS'(cell_i.side.frac) - REL_BITS'(cell_i.rem)
                  + REL_BITS'(cell_i.side.ivl);
    delay_sum     = {1'b0, cell_i.side.vote} + {1'b0, cell_i.side.pub};
    delay_long    = delay_sum > {2'b00, cell_i.side.ivl[REG_BITS-1:1]};
    p1_vote_d     = delay_long ? (cell_i.side.ivl >> 2) : cell_i.side.vote;
    p1_dist_d     = delay_long ? (cell_i.side.ivl >> 2) : cell_i.side.pub;
  end

  // never past next midnight; short final interval folds into tomorrow
  always_comb begin
    day_next = (p1_next_q > REL_BITS'(DAY_SECONDS)) ? REL_BITS'(DAY_SECONDS) : p1_next_q;
    if (day_next + REL_BITS'(p1_ivl_q >> 1) > REL_BITS'(DAY_SECONDS)) begin
      day_next = REL_BITS'(DAY_SECONDS);
    end
    p2_next_d = day_next + REL_BITS'(start_offset_i);
  end

  // step back one interval when the offset overshoots now
  always_comb begin
    step_limit = REL_BITS'(p2_frac_q) + REL_BITS'(p2_ivl_q);
    p3_rel_d   = (p2_next_q > step_limit) ? p2_next_q - REL_BITS'(p2_ivl_q) : p2_next_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else if (en_i) begin
      p1_valid_q <= valid_i;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_midnight_q <= p1_midnight_d;
      p1_next_q     <= p1_next_d;
      p1_frac_q     <= cell_i.side.frac;
      p1_ivl_q      <= cell_i.side.ivl;
      p1_vote_q     <= p1_vote_d;
      p1_dist_q     <= p1_dist_d;
      p1_ok_q       <= cell_i.side.ok;

      p2_midnight_q <= p1_midnight_q;
      p2_next_q     <= p2_next_d;
      p2_frac_q     <= p1_frac_q;
      p2_ivl_q      <= p1_ivl_q;
      p2_vote_q     <= p1_vote_q;
      p2_dist_q     <= p1_dist_q;
      p2_ok_q       <= p1_ok_q;

      p3_midnight_q <= p2_midnight_q;
      p3_rel_q      <= p3_rel_d;
      p3_dhalf_q    <= REL_BITS'(p2_dist_q >> 1);
      p3_dfull_q    <= REL_BITS'(p2_dist_q);
      p3_dvhalf_q   <= REL_BITS'(p2_dist_q) + REL_BITS'(p2_vote_q >> 1);
      p3_dvfull_q   <= REL_BITS'(p2_dist_q) + REL_BITS'(p2_vote_q);
      p3_ok_q       <= p2_ok_q;

      p4_start_q    <= OUT_BITS'(p3_midnight_q) + OUT_BITS'(p3_rel_q);
      p4_dhalf_q    <= p3_dhalf_q;
      p4_dfull_q    <= p3_dfull_q;
      p4_dvhalf_q   <= p3_dvhalf_q;
      p4_dvfull_q   <= p3_dvfull_q;
      p4_ok_q       <= p3_ok_q;
    end
  end

  // bad interval: all times zero
  always_comb begin
    res_o = '0;
    res_o.bad = !p4_ok_q;
    if (p4_ok_q) begin
      res_o.start       = p4_start_q;
      res_o.fetch_sig   = p4_start_q - OUT_BITS'(p4_dhalf_q);
      res_o.vote_end    = p4_start_q - OUT_BITS'(p4_dfull_q);
      res_o.fetch_votes = p4_start_q - OUT_BITS'(p4_dvhalf_q);
      res_o.vote_start  = p4_start_q - OUT_BITS'(p4_dvfull_q);
    end
  end

  assign valid_o = p4_valid_q;

endmodule

// ===== rtl/vis_skid.sv =====
// ----------------------------------------------------------------------------
// vis_skid : output register with one skid entry
// Upstream ready is a register, so the stall does not ripple back
// combinationally from the receiver into the pipeline.
// ----------------------------------------------------------------------------
module vis_skid import vis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  res_t push_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, skid_q;
  logic push, pop;
  logic load_out_new, load_out_skid, load_skid;

  assign push = push_valid_i && !skid_valid_q;
  assign pop  = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_new  = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        load_out_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        load_out_new = 1'b1;
        out_valid_d  = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_new) begin
      out_q <= push_data_i;
    end else if (load_out_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= push_data_i;
    end
  end

  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

endmodule

// ===== rtl/vote_interval_schedule.sv =====
// ----------------------------------------------------------------------------
// vote_interval_schedule : voting timetable for one query time
// Per request: pick interval and delays, align the next interval start to
// UTC midnight and derive the four voting deadlines.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on the s_axis channel (time, consensus timing, with the
//   consensus-present flag on tuser); results leave on m_axis with the
//   start and four deadlines on tdata and the bad-interval flag on tuser.
//   Configuration writes (interval, vote delay, distribution delay, start
//   offset) use the cfg channel, always ready; write only while idle.
// Pipeline / throughput
//   Registers from the accepting edge to m_axis_tvalid: input register,
//   selection stage, 40 cells for now mod 86400, 17 cells dividing the
//   time of day by the interval, four schedule stages, output register.
//   One request per cycle while the chain is not held; the chain of
//   division cells, one quotient bit per cell, sets the latency.
// Reset
//   All request slots are emptied and the registers take their defaults
//   (1800 s interval, 300 s delays, no offset). No clearing pass.
// Back-pressure
//   While m_axis_tready is low the chain keeps moving until a second result
//   reaches the tail; that one goes to a skid entry, and from the next cycle
//   s_axis_tready is low and the whole chain holds until the result waiting
//   on m_axis is taken.
// ----------------------------------------------------------------------------
module vote_interval_schedule import vis_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request: now, consensus start, consensus end, vote lead, publish lead
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                     s_axis_tuser,   // consensus_present
  // result: interval_start, fetch_signatures_at, voting_end_at,
  //         fetch_votes_at, voting_start_at
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                     m_axis_tuser,   // bad_interval
  // register writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [REG_BITS-1:0]      cfg_data_i
);

  // configuration registers
  logic [REG_BITS-1:0] cfg_interval_q, cfg_vote_q, cfg_dist_q, cfg_offset_q;

  // chain advance, driven by the skid stage
  logic en;

  // input register
  logic                 s0_valid_q;
  logic [TIME_BITS-1:0] s0_now_q, s0_va_q, s0_fu_q;
  logic [REG_BITS-1:0]  s0_vote_q, s0_dist_q;
  logic                 s0_have_q;

  // selection stage
  logic                 s1_valid_q;
  side_t                s1_side_q, s1_side_d;
  logic [TIME_BITS-1:0] cons_ivl;
  logic                 cons_ok, cfg_ok;

  // cell chains
  logic  mod_valid [MOD_CELLS];
  cell_t mod_cell  [MOD_CELLS];
  logic  div_valid [DIV_CELLS];
  cell_t div_cell  [DIV_CELLS];
  cell_t mod_head, div_head;

  // tail and output
  logic tail_valid, push_ready;
  res_t tail_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_interval_q <= INTERVAL_RST;
      cfg_vote_q     <= VOTE_LEAD_RST;
      cfg_dist_q     <= PUB_LEAD_RST;
      cfg_offset_q   <= START_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INTERVAL:     cfg_interval_q <= cfg_data_i;
        REG_VOTE_LEAD:    cfg_vote_q     <= cfg_data_i;
        REG_PUB_LEAD:     cfg_dist_q     <= cfg_data_i;
        REG_START_OFFSET: cfg_offset_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = push_ready;
  assign s_axis_tready = en;

  // input capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= s_axis_tvalid;
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_now_q  <= s_axis_tdata[IN_NOW_LSB +: TIME_BITS];
      s0_va_q   <= s_axis_tdata[IN_VA_LSB +: TIME_BITS];
      s0_fu_q   <= s_axis_tdata[IN_FU_LSB +: TIME_BITS];
      s0_vote_q <= s_axis_tdata[IN_VOTE_LSB +: REG_BITS];
      s0_dist_q <= s_axis_tdata[IN_DIST_LSB +: REG_BITS];
      s0_have_q <= s_axis_tuser;
      s1_side_q <= s1_side_d;
    end
  end

  // interval and delays: consensus timing or register defaults
  always_comb begin
    cons_ivl  = s0_fu_q - s0_va_q;
    cons_ok   = (s0_fu_q > s0_va_q) && (cons_ivl <= TIME_BITS'(DAY_SECONDS));
    cfg_ok    = (cfg_interval_q != '0) && (cfg_interval_q <= DAY_SECONDS);
    s1_side_d.now  = s0_now_q;
    s1_side_d.frac = '0;
    if (s0_have_q) begin
      s1_side_d.ivl  = cons_ivl[REG_BITS-1:0];
      s1_side_d.ok   = cons_ok;
      s1_side_d.vote = s0_vote_q;
      s1_side_d.pub  = s0_dist_q;
    end else begin
      s1_side_d.ivl  = cfg_interval_q;
      s1_side_d.ok   = cfg_ok;
      s1_side_d.vote = cfg_vote_q;
      s1_side_d.pub  = cfg_dist_q;
    end
  end

  // first chain: now mod 86400, full time word shifted through
  always_comb begin
    mod_head      = '0;
    mod_head.dvd  = s1_side_q.now;
    mod_head.dsr  = DAY_SECONDS;
    mod_head.side = s1_side_q;
  end

  for (genvar k = 0; k < MOD_CELLS; k++) begin : g_mod
    if (k == 0) begin : g_first
      vis_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (s1_valid_q),
        .cell_i  (mod_head),
        .valid_o (mod_valid[k]),
        .cell_o  (mod_cell[k])
      );
    end else begin : g_next
      vis_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (mod_valid[k-1]),
        .cell_i  (mod_cell[k-1]),
        .valid_o (mod_valid[k]),
        .cell_o  (mod_cell[k])
      );
    end
  end

  // second chain: time of day divided by the interval; the time of day is
  // placed at the top of the dividend so only REG_BITS steps are needed
  always_comb begin
    div_head           = '0;
    div_head.dvd       = {mod_cell[MOD_CELLS-1].rem, {(TIME_BITS - REG_BITS){1'b0}}};
    div_head.dsr       = mod_cell[MOD_CELLS-1].side.ivl;
    div_head.side      = mod_cell[MOD_CELLS-1].side;
    div_head.side.frac = mod_cell[MOD_CELLS-1].rem;
  end

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    if (k == 0) begin : g_first
      vis_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (mod_valid[MOD_CELLS-1]),
        .cell_i  (div_head),
        .valid_o (div_valid[k]),
        .cell_o  (div_cell[k])
      );
    end else begin : g_next
      vis_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (div_valid[k-1]),
        .cell_i  (div_cell[k-1]),
        .valid_o (div_valid[k]),
        .cell_o  (div_cell[k])
      );
    end
  end

  vis_tail u_tail (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (div_valid[DIV_CELLS-1]),
    .cell_i         (div_cell[DIV_CELLS-1]),
    .start_offset_i (cfg_offset_q),
    .valid_o        (tail_valid),
    .res_o          (tail_res)
  );

  vis_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (tail_valid),
    .push_ready_o (push_ready),
    .push_data_i  (tail_res),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_res)
  );

  // pack result, first field lowest, zero fill to whole bytes
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OUT_FIELD_BITS-1:0] = {out_res.vote_start, out_res.fetch_votes,
                                        out_res.vote_end, out_res.fetch_sig,
                                        out_res.start};
  end
  assign m_axis_tuser = out_res.bad;

endmodule

// ===== rtl/vis_checker.sv =====
// ----------------------------------------------------------------------------
// vis_checker : port-level checks for the vote interval schedule
// Result consistency and stall behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
module vis_checker import vis_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                     m_axis_tuser
);

  logic [OUT_BITS-1:0] start, fetch_sig, vote_end, fetch_votes, vote_start;
  logic [OUT_BITS-1:0] lead_sig, lead_end, lead_votes, lead_start;

  assign start       = m_axis_tdata[0 +: OUT_BITS];
  assign fetch_sig   = m_axis_tdata[OUT_BITS +: OUT_BITS];
  assign vote_end    = m_axis_tdata[2 * OUT_BITS +: OUT_BITS];
  assign fetch_votes = m_axis_tdata[3 * OUT_BITS +: OUT_BITS];
  assign vote_start  = m_axis_tdata[4 * OUT_BITS +: OUT_BITS];

  // how far each deadline lies before the start
  assign lead_sig   = start - fetch_sig;
  assign lead_end   = start - vote_end;
  assign lead_votes = start - fetch_votes;
  assign lead_start = start - vote_start;

  // a bad interval carries no times
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad interval result carries nonzero times");

  // deadlines come in order: voting start, fetch votes, voting end, fetch sigs
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (lead_end >= lead_sig) && (lead_votes >= lead_end) && (lead_start >= lead_votes))
    else $error("voting deadlines out of order");

  // input back-pressure only follows a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("request side stalled without output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind vote_interval_schedule vis_checker u_vis_checker (.*);

// ===== sim/tb_vote_interval_schedule.sv =====
// ----------------------------------------------------------------------------
// tb_vote_interval_schedule : self-checking bench for the voting timetable
// Sends time requests, with and without consensus timing, through several
// register settings and flow-control patterns. Each result is checked field
// by field against a schedule that the bench works out for itself.
// ----------------------------------------------------------------------------
module tb_vote_interval_schedule;
  timeunit 1ns;
  timeprecision 1ps;

  import vis_pkg::*;

  localparam longint unsigned SECS_PER_DAY = 24 * 60 * 60;
  // last whole day that still fits below 2^TIME_BITS
  localparam longint unsigned LAST_DAY     = 12725828;
  // a day well away from zero, for directed requests around midnight
  localparam longint unsigned DAY_BASE     = 64'd12345 * SECS_PER_DAY;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // one time request, fields at the block's widths
  typedef struct packed {
    logic [TIME_BITS-1:0] now;
    logic                 present;
    logic [TIME_BITS-1:0] va;
    logic [TIME_BITS-1:0] fu;
    logic [REG_BITS-1:0]  vote;
    logic [REG_BITS-1:0]  pub;
  } query_t;

  // one timetable: start, four deadlines, bad-interval flag
  typedef struct packed {
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] sig_fetch;
    logic [OUT_BITS-1:0] vote_end;
    logic [OUT_BITS-1:0] votes_fetch;
    logic [OUT_BITS-1:0] vote_begin;
    logic                bad;
  } sched_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = '0;
  logic [REG_BITS-1:0]      cfg_data_i    = '0;

  vote_interval_schedule u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  // bench copy of the registers, updated on each accepted write
  logic [REG_BITS-1:0] ivl_cfg    = INTERVAL_RST;
  logic [REG_BITS-1:0] vote_cfg   = VOTE_LEAD_RST;
  logic [REG_BITS-1:0] dist_cfg   = PUB_LEAD_RST;
  logic [REG_BITS-1:0] offset_cfg = START_OFFSET_RST;

  sched_t timetable_q[$];   // timetables owed by the block, oldest first
  int     fail_count   = 0;
  int     tx_idle_pct  = 0; // chance per cycle that the sender holds back
  int     rx_stall_pct = 0; // chance per cycle that the receiver stalls
  int     hold_request = 0; // asks the receiver for a long hold-off

  // --------------------------------------------------------------------------
  // clock, reset release in the stimulus process, overall time limit
  // --------------------------------------------------------------------------
  initial forever #5 clk_i = ~clk_i;

  // ends the run with an error if it hangs
  initial begin : watchdog
    #(4_000_000);
    $display("tb_vote_interval_schedule: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // timetable predictor
  // --------------------------------------------------------------------------
  // Interval and delays come from the consensus when present, else from the
  // registers. Start is the next interval boundary counted from UTC midnight,
  // capped at the next midnight, with a short last interval folded into the
  // next day; then the offset goes on and one interval comes off again if
  // the start now lies more than an interval ahead of the query time.
  function automatic sched_t plan_timetable(query_t q);
    longint unsigned span, vote, pub, now, midnight, tomorrow, nxt;
    bit              ok;
    sched_t          s;
    s   = '0;
    now = 64'(q.now);
    if (q.present) begin
      ok   = (q.fu > q.va) && (64'(q.fu) - 64'(q.va) <= SECS_PER_DAY);
      span = ok ? 64'(q.fu) - 64'(q.va) : 64'd0;
      vote = 64'(q.vote);
      pub  = 64'(q.pub);
    end else begin
      span = 64'(ivl_cfg);
      ok   = (span >= 1) && (span <= SECS_PER_DAY);
      vote = 64'(vote_cfg);
      pub  = 64'(dist_cfg);
    end
    if (!ok) begin
      s.bad = 1'b1;
      return s;
    end
    // delays that eat more than half the interval shrink to a quarter each
    if (vote + pub > span / 2) begin
      vote = span / 4;
      pub  = span / 4;
    end
    midnight = now - now % SECS_PER_DAY;
    tomorrow = midnight + SECS_PER_DAY;
    nxt      = midnight + ((now - midnight) / span + 1) * span;
    if (nxt > tomorrow) nxt = tomorrow;
    if (nxt + span / 2 > tomorrow) nxt = tomorrow;
    nxt += 64'(offset_cfg);
    if (nxt - span > now) nxt -= span;
    // deadlines wrap to OUT_BITS two's complement
    s.start       = OUT_BITS'(nxt);
    s.sig_fetch   = OUT_BITS'(nxt - pub / 2);
    s.vote_end    = OUT_BITS'(nxt - pub);
    s.votes_fetch = OUT_BITS'(nxt - pub - vote / 2);
    s.vote_begin  = OUT_BITS'(nxt - pub - vote);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // random field values
  // --------------------------------------------------------------------------
  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom(), $urandom()});
  endfunction

  // favour the interesting lengths: one second, a whole day, divisors of a
  // day, one with a short last interval, one longer than half a day
  function automatic logic [REG_BITS-1:0] pick_interval();
    case ($urandom_range(0, 7))
      0:       return REG_BITS'(1);
      1:       return REG_BITS'(86400);
      2:       return REG_BITS'(1800);
      3:       return REG_BITS'(3600);
      4:       return REG_BITS'(1000);
      5:       return REG_BITS'(50000);
      default: return REG_BITS'($urandom_range(1, 86400));
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] rand_delay();
    if ($urandom_range(0, 2) == 0) return REG_BITS'($urandom_range(0, 86400));
    return REG_BITS'($urandom_range(0, 2000));
  endfunction

  // mostly well-formed consensus windows; some empty, reversed, too long
  // or wrapping past the top of the time range
  function automatic query_t random_query();
    query_t              q;
    logic [REG_BITS-1:0] span;
    longint unsigned     day;
    day = 64'($urandom_range(0, 32'(LAST_DAY)));
    case ($urandom_range(0, 9))
      0, 1:    q.now = TIME_BITS'(day * SECS_PER_DAY + SECS_PER_DAY
                                  - 64'($urandom_range(1, 3000)));
      2:       q.now = TIME_BITS'($urandom_range(0, 200000));
      default: q.now = rand_time();
    endcase
    q.present = ($urandom_range(0, 99) < 60);
    span      = pick_interval();
    q.va      = rand_time();
    case ($urandom_range(0, 19))
      0:       q.fu = rand_time();
      1:       q.fu = q.va;
      2:       q.fu = q.va + TIME_BITS'(86401 + $urandom_range(0, 1000));
      3:       q.fu = q.va - TIME_BITS'($urandom_range(1, 1000));
      4: begin
        q.va = TIME_MAX - TIME_BITS'($urandom_range(0, 86400));
        q.fu = q.va + TIME_BITS'(span);
      end
      default: q.fu = q.va + TIME_BITS'(span);
    endcase
    q.vote = rand_delay();
    q.pub  = rand_delay();
    return q;
  endfunction

  // request without consensus; the ignored fields still carry noise
  function automatic query_t idle_query(logic [TIME_BITS-1:0] now);
    query_t q;
    q         = random_query();
    q.now     = now;
    q.present = 1'b0;
    return q;
  endfunction

  function automatic query_t consensus_query(logic [TIME_BITS-1:0] now,
                                             logic [TIME_BITS-1:0] va,
                                             logic [TIME_BITS-1:0] fu,
                                             logic [REG_BITS-1:0]  vote,
                                             logic [REG_BITS-1:0]  pub);
    query_t q;
    q = '{now: now, present: 1'b1, va: va, fu: fu, vote: vote, pub: pub};
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // request sender
  // --------------------------------------------------------------------------
  // Random gaps before each request; valid stays high between back-to-back
  // requests. The timetable is queued at the accepting edge, when the
  // registers are known to be steady.
  task automatic send_query(input query_t q);
    logic [IN_DATA_BITS-1:0] data;
    data = '0;
    data[IN_NOW_LSB  +: TIME_BITS] = q.now;
    data[IN_VA_LSB   +: TIME_BITS] = q.va;
    data[IN_FU_LSB   +: TIME_BITS] = q.fu;
    data[IN_VOTE_LSB +: REG_BITS]  = q.vote;
    data[IN_DIST_LSB +: REG_BITS]  = q.pub;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= q.present;
    do @(posedge clk_i); while (!s_axis_tready);
    timetable_q.push_back(plan_timetable(q));
  endtask

  // drop valid and wait until every owed timetable has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (timetable_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // register writes, only once the block has drained
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_e idx, input logic [REG_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INTERVAL:     ivl_cfg    = val;
      REG_VOTE_LEAD:    vote_cfg   = val;
      REG_PUB_LEAD:     dist_cfg   = val;
      REG_START_OFFSET: offset_cfg = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [REG_BITS-1:0] span,
                               input logic [REG_BITS-1:0] vote,
                               input logic [REG_BITS-1:0] pub,
                               input logic [REG_BITS-1:0] offset);
    settle();
    write_reg(REG_INTERVAL, span);
    write_reg(REG_VOTE_LEAD, vote);
    write_reg(REG_PUB_LEAD, pub);
    write_reg(REG_START_OFFSET, offset);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off counted here on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stretch;
    stretch = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        stretch      = hold_request;
        hold_request = 0;
      end
      if (stretch > 0) begin
        stretch--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker: each accepted result against the oldest owed timetable
  // --------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [OUT_BITS-1:0] want,
                                        logic [OUT_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    sched_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.start       = m_axis_tdata[0 * OUT_BITS +: OUT_BITS];
      got.sig_fetch   = m_axis_tdata[1 * OUT_BITS +: OUT_BITS];
      got.vote_end    = m_axis_tdata[2 * OUT_BITS +: OUT_BITS];
      got.votes_fetch = m_axis_tdata[3 * OUT_BITS +: OUT_BITS];
      got.vote_begin  = m_axis_tdata[4 * OUT_BITS +: OUT_BITS];
      got.bad         = m_axis_tuser;
      if (timetable_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = timetable_q.pop_front();
        compare_field("interval_start", want.start, got.start);
        compare_field("fetch_signatures_at", want.sig_fetch, got.sig_fetch);
        compare_field("voting_end_at", want.vote_end, got.vote_end);
        compare_field("fetch_votes_at", want.votes_fetch, got.votes_fetch);
        compare_field("voting_start_at", want.vote_begin, got.vote_begin);
        compare_field("bad_interval", OUT_BITS'(want.bad), OUT_BITS'(got.bad));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // Field extremes, broken consensus windows, delay clamp at and just past
  // half the interval, folding of a short last interval, capping at
  // midnight, start offset pulling deadlines below zero, bad registers.
  task automatic test_directed_cases();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_query(idle_query('0));
    send_query(idle_query(TIME_MAX));
    send_query(idle_query(TIME_BITS'(DAY_BASE + 86399)));
    send_query(idle_query(TIME_BITS'(DAY_BASE + 86400)));
    send_query(consensus_query(rand_time(), '0, '0, 17'd0, 17'd0));
    send_query(consensus_query(rand_time(), 40'd1000, 40'd999, 17'd10, 17'd10));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 43210), '0, 40'd86400,
                               17'd0, 17'd0));
    send_query(consensus_query(rand_time(), 40'd5, 40'd86406, 17'd1, 17'd1));
    send_query(consensus_query(rand_time(), TIME_MAX, '0, 17'd1, 17'd1));
    send_query(consensus_query(rand_time(), 40'd100, 40'd101, 17'd0, 17'd0));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 100), '0, 40'd3600,
                               17'd900, 17'd900));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 100), '0, 40'd3600,
                               17'd901, 17'd900));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 100), '0, 40'd3600,
                               17'd86400, 17'd86400));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 86000), '0, 40'd1000,
                               17'd10, 17'd10));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 85499), '0, 40'd1000,
                               17'd10, 17'd10));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 60000), '0, 40'd50000,
                               17'd0, 17'd0));
    send_query(consensus_query(TIME_BITS'(DAY_BASE + 86395), '0, 40'd7,
                               17'd1, 17'd1));
    send_query(consensus_query(TIME_MAX, TIME_MAX - 40'd3600, TIME_MAX,
                               17'd65535, 17'd65535));
    // small offset near the epoch: deadlines go negative
    apply_setting(17'd1800, 17'd300, 17'd300, 17'd10);
    send_query(idle_query(40'd5));
    send_query(idle_query(TIME_BITS'(DAY_BASE + 1795)));
    // everything at its largest
    apply_setting(17'd86400, 17'd86400, 17'd86400, 17'd86400);
    send_query(idle_query(TIME_BITS'(DAY_BASE + 86399)));
    send_query(consensus_query(TIME_MAX, '0, 40'd86400, 17'd0, 17'd86400));
    // interval registers outside one second to one day
    apply_setting(17'd0, 17'd300, 17'd300, 17'd0);
    send_query(idle_query(rand_time()));
    apply_setting(17'd86401, 17'd300, 17'd300, 17'd0);
    send_query(idle_query(rand_time()));
  endtask

  task automatic test_random_traffic(input int count, input int tx_idle,
                                     input int rx_stall);
    tx_idle_pct  = tx_idle;
    rx_stall_pct = rx_stall;
    repeat (count) send_query(random_query());
  endtask

  // receiver holds off well past the pipeline depth while the sender keeps
  // offering, so the block fills and pushes back on its input
  task automatic test_output_hold();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_request = 400;
    repeat (150) send_query(random_query());
  endtask

  // sender goes quiet until the block has handed back every result
  task automatic test_sender_pause();
    tx_idle_pct  = 28;
    rx_stall_pct = 28;
    repeat (50) send_query(random_query());
    settle();
    repeat (50) send_query(random_query());
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();

    apply_setting(17'd1, 17'd0, 17'd0, 17'd0);
    test_random_traffic(200, 0, 0);
    apply_setting(17'd86400, 17'd86400, 17'd86400, 17'd86400);
    test_random_traffic(250, 85, 0);
    apply_setting(17'd3600, 17'd300, 17'd300, 17'd1800);
    test_random_traffic(250, 0, 85);
    apply_setting(pick_interval(), rand_delay(), rand_delay(),
                  REG_BITS'($urandom_range(0, 86400)));
    test_random_traffic(250, 28, 28);
    apply_setting(17'd1000, 17'd100, 17'd50, 17'd0);
    test_random_traffic(200, 0, 0);
    apply_setting(17'd43200, 17'd0, 17'd86400, 17'd1);
    test_random_traffic(250, 28, 28);

    apply_setting(pick_interval(), rand_delay(), rand_delay(),
                  REG_BITS'($urandom_range(0, 86400)));
    test_output_hold();
    test_sender_pause();

    // drain, then allow a pipeline's worth of cycles for stray results
    settle();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_vote_interval_schedule: clean");
    end else begin
      $display("tb_vote_interval_schedule: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vis_pkg.sv
rtl/vis_cell.sv
rtl/vis_tail.sv
rtl/vis_skid.sv
rtl/vote_interval_schedule.sv
rtl/vis_checker.sv
sim/tb_vote_interval_schedule.sv
